>>> src/sqg_pkg.sv
// ----------------------------------------------------------------------------
// sqg_pkg: shared types and constants for the single-qubit gate engine
// Payload structs, op and status codes, sequencer states.
// ----------------------------------------------------------------------------
package sqg_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_WIDTH_DEF  = 16;
    localparam int GATE_FRAC      = 14;
    localparam int QC_W           = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_APPLY = 2'd2,
        OP_KET0  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_TGT = 2'd1,
        ST_BAD_IDX = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         amp_index;
        logic signed [15:0] amp_real;
        logic signed [15:0] amp_imag;
        logic [3:0]         target_qubit;
        logic [31:0]        gate_00;
        logic [31:0]        gate_01;
        logic [31:0]        gate_10;
        logic [31:0]        gate_11;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_real;
        logic signed [15:0] out_imag;
        logic [1:0]         status;
    } t_out_item;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  status;
        logic [9:0]  amp_index;
        logic [15:0] amp_real;
        logic [15:0] amp_imag;
        logic [3:0]  target_qubit;
        logic [QC_W-1:0] nq;
        logic [127:0] gate;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_WRITE,
        S_RD_ADDR,
        S_RD_WAIT,
        S_AP_RD,
        S_AP_WAIT,
        S_AP_CALC,
        S_AP_SUM,
        S_AP_WR,
        S_RESULT
    } t_state;

endpackage

>>> src/single_qubit_gate_apply.sv
// ----------------------------------------------------------------------------
// single_qubit_gate_apply: single-qubit gate engine over a state vector
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------
//  input    | i_valid/o_stall  | sqg_pkg::t_in_item
//  output   | o_valid/i_stall  | sqg_pkg::t_out_item
//  config   | i_cfg_valid/o_cfg_ready | qubit_count
//
// Per command, idle to result: a write via the write state, a read via address
// and wait states, an error straight to the result, ket zero as a sweep of the
// store, apply as 2^(nq-1) pairs with nq the qubit count clamped to MAX_QUBITS
// (per pair: read, wait, multiply, sum, two writes on the one write port); then
// back to idle. After reset the store is swept first.
// A stalled result holds the sequencer; o_stall rises with two items queued.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sqg_pkg::AMP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sqg_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output sqg_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [sqg_pkg::QC_W-1:0] i_cfg_data
);
    logic [sqg_pkg::QC_W-1:0] r_qc;
    logic          w_cmd_valid, w_pop;
    sqg_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qc <= sqg_pkg::QC_W'(1);
        else if (i_cfg_valid) r_qc <= i_cfg_data;
    end

    sqg_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .i_qubit_count(r_qc), .o_cmd_valid(w_cmd_valid),
        .i_cmd_pop(w_pop), .o_cmd(w_cmd));

    sqg_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .o_valid, .i_stall, .o_item);
endmodule

>>> src/sqg_ram.sv
// ----------------------------------------------------------------------------
// sqg_ram: generic single-write, dual-read RAM
// Registered read data on both read ports.
// ----------------------------------------------------------------------------
module sqg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

>>> src/sqg_front.sv
// ----------------------------------------------------------------------------
// sqg_front: command intake and classification
// Checks target and index against the qubit count and queues the command.
// ----------------------------------------------------------------------------
module sqg_front #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sqg_pkg::t_in_item     i_item,
    input  logic [sqg_pkg::QC_W-1:0] i_qubit_count,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_pop,
    output sqg_pkg::t_cmd         o_cmd
);
    localparam int QD = 2;

    sqg_pkg::t_cmd r_q [QD];
    logic [1:0]    r_cnt, n_cnt;
    logic          r_wp, r_rp;
    sqg_pkg::t_cmd w_cmd;
    logic [sqg_pkg::QC_W-1:0] w_nq;
    logic          w_push;

    assign o_stall = (r_cnt == 2'(QD));
    assign w_push  = i_valid && !o_stall;
    assign w_nq    = (int'(i_qubit_count) > MAX_QUBITS) ?
                     sqg_pkg::QC_W'(MAX_QUBITS) : i_qubit_count;

    always_comb begin
        w_cmd              = '0;
        w_cmd.op           = i_item.op;
        w_cmd.amp_index    = i_item.amp_index;
        w_cmd.amp_real     = i_item.amp_real;
        w_cmd.amp_imag     = i_item.amp_imag;
        w_cmd.target_qubit = i_item.target_qubit;
        w_cmd.nq           = w_nq;
        w_cmd.gate         = {i_item.gate_00, i_item.gate_01,
                              i_item.gate_10, i_item.gate_11};
        w_cmd.status       = sqg_pkg::ST_OK;
        unique case (sqg_pkg::t_op'(i_item.op))
            sqg_pkg::OP_WRITE, sqg_pkg::OP_READ: begin
                // any index bit at or above the qubit count is out of range
                if ((i_item.amp_index >> w_nq) != 10'd0) w_cmd.status = sqg_pkg::ST_BAD_IDX;
            end
            sqg_pkg::OP_APPLY: begin
                if (i_item.target_qubit >= w_nq) w_cmd.status = sqg_pkg::ST_BAD_TGT;
            end
            sqg_pkg::OP_KET0: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) n_cnt = r_cnt + 2'd1;
        else if (!w_push && i_cmd_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
endmodule

>>> src/sqg_back.sv
// ----------------------------------------------------------------------------
// sqg_back: state store sequencer
// Runs write, read, ket-zero clear and pairwise gate passes over the store.
// ----------------------------------------------------------------------------
module sqg_back #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sqg_pkg::AMP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  sqg_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output sqg_pkg::t_out_item o_item
);
    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int W     = AMP_WIDTH;
    localparam int PW    = W + 16;       // product width
    localparam int SW    = PW + 2;       // sum of four products
    localparam int F     = sqg_pkg::GATE_FRAC;
    localparam logic signed [W-1:0] ONE = W'(1) <<< (W - 2);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    sqg_pkg::t_state r_state, n_state;
    sqg_pkg::t_cmd   r_cmd;
    logic [AW:0]     r_cnt;     // clear address or pair counter
    logic [AW-1:0]   r_ia, r_ja;
    logic            r_wsel;    // 0 writes entry i, 1 writes entry j
    logic            r_out_v;
    sqg_pkg::t_out_item r_out;
    logic            r_clr_done;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_ra, w_rb;
    logic [W-1:0]  w_wre, w_wim, w_dre_a, w_dre_b, w_dim_a, w_dim_b;

    sqg_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_re (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wre),
        .i_raddr_a(w_ra), .i_raddr_b(w_rb), .o_rdata_a(w_dre_a), .o_rdata_b(w_dre_b));
    sqg_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_im (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wim),
        .i_raddr_a(w_ra), .i_raddr_b(w_rb), .o_rdata_a(w_dim_a), .o_rdata_b(w_dim_b));

    function automatic logic signed [W-1:0] sat_in(input logic signed [15:0] v);
        logic signed [47:0] e;
        e = 48'(v);
        if (e > 48'(WMAX)) sat_in = WMAX;
        else if (e < 48'(WMIN)) sat_in = WMIN;
        else sat_in = W'(e);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [W-1:0] v);
        logic signed [47:0] e;
        e = 48'(v);
        if (e > 48'sd32767) sat16 = 16'sh7fff;
        else if (e < -48'sd32768) sat16 = 16'sh8000;
        else sat16 = 16'(e);
    endfunction

    function automatic logic signed [W-1:0] rescale(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [SW-F-1:0] q;
        t = v + SW'(1 << (F - 1));
        q = t[SW-1:F];
        if (q > (SW-F)'(WMAX)) rescale = WMAX;
        else if (q < (SW-F)'(WMIN)) rescale = WMIN;
        else rescale = W'(q);
    endfunction

    // pair index: insert a zero at the target bit of the counter
    logic [AW-1:0] w_pi, w_low, w_mask;
    logic [AW:0]   w_pairs;
    assign w_mask  = AW'((AW+1)'(1) << r_cmd.target_qubit);
    assign w_low   = w_mask - AW'(1);
    assign w_pi    = ((r_cnt[AW-1:0] & ~w_low) << 1) | (r_cnt[AW-1:0] & w_low);
    assign w_pairs = (AW+1)'(1) << (r_cmd.nq - sqg_pkg::QC_W'(1));

    // products and sums
    logic signed [W-1:0]  r_ar, r_ai, r_br, r_bi;
    logic signed [PW-1:0] r_p [16];
    logic signed [SW-1:0] r_s [4];
    logic signed [15:0]   w_gr [4], w_gi [4];
    logic signed [W-1:0]  r_nre_j, r_nim_j;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            w_gr[g] = r_cmd.gate[127-32*g -: 16];
            w_gi[g] = r_cmd.gate[111-32*g -: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sqg_pkg::S_AP_WAIT) begin
            r_ar <= w_dre_a; r_ai <= w_dim_a; r_br <= w_dre_b; r_bi <= w_dim_b;
        end
        if (r_state == sqg_pkg::S_AP_CALC) begin
            for (int k = 0; k < 2; k++) begin
                r_p[8*k+0] <= PW'(w_gr[2*k]) * PW'(r_ar);
                r_p[8*k+1] <= PW'(w_gi[2*k]) * PW'(r_ai);
                r_p[8*k+2] <= PW'(w_gr[2*k+1]) * PW'(r_br);
                r_p[8*k+3] <= PW'(w_gi[2*k+1]) * PW'(r_bi);
                r_p[8*k+4] <= PW'(w_gr[2*k]) * PW'(r_ai);
                r_p[8*k+5] <= PW'(w_gi[2*k]) * PW'(r_ar);
                r_p[8*k+6] <= PW'(w_gr[2*k+1]) * PW'(r_bi);
                r_p[8*k+7] <= PW'(w_gi[2*k+1]) * PW'(r_br);
            end
        end
        if (r_state == sqg_pkg::S_AP_SUM) begin
            for (int k = 0; k < 2; k++) begin
                r_s[2*k]   <= SW'(r_p[8*k]) - SW'(r_p[8*k+1]) + SW'(r_p[8*k+2])
                              - SW'(r_p[8*k+3]);
                r_s[2*k+1] <= SW'(r_p[8*k+4]) + SW'(r_p[8*k+5]) + SW'(r_p[8*k+6])
                              + SW'(r_p[8*k+7]);
            end
        end
        if (r_state == sqg_pkg::S_AP_WR && !r_wsel) begin
            r_nre_j <= rescale(r_s[2]);
            r_nim_j <= rescale(r_s[3]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqg_pkg::S_IDLE: begin
                if (!r_clr_done) n_state = sqg_pkg::S_CLEAR;
                else if (i_cmd_valid && !r_out_v) begin
                    if (i_cmd.status != sqg_pkg::ST_OK) n_state = sqg_pkg::S_RESULT;
                    else begin
                        unique case (sqg_pkg::t_op'(i_cmd.op))
                            sqg_pkg::OP_WRITE: n_state = sqg_pkg::S_WRITE;
                            sqg_pkg::OP_READ:  n_state = sqg_pkg::S_RD_ADDR;
                            sqg_pkg::OP_APPLY: n_state = sqg_pkg::S_AP_RD;
                            sqg_pkg::OP_KET0:  n_state = sqg_pkg::S_CLEAR;
                        endcase
                    end
                end
            end
            sqg_pkg::S_CLEAR:
                if (r_cnt == (AW+1)'(DEPTH - 1))
                    n_state = r_clr_done ? sqg_pkg::S_RESULT : sqg_pkg::S_IDLE;
            sqg_pkg::S_WRITE:   n_state = sqg_pkg::S_RESULT;
            sqg_pkg::S_RD_ADDR: n_state = sqg_pkg::S_RD_WAIT;
            sqg_pkg::S_RD_WAIT: n_state = sqg_pkg::S_RESULT;
            sqg_pkg::S_AP_RD:   n_state = sqg_pkg::S_AP_WAIT;
            sqg_pkg::S_AP_WAIT: n_state = sqg_pkg::S_AP_CALC;
            sqg_pkg::S_AP_CALC: n_state = sqg_pkg::S_AP_SUM;
            sqg_pkg::S_AP_SUM:  n_state = sqg_pkg::S_AP_WR;
            sqg_pkg::S_AP_WR:
                if (r_wsel) n_state = (r_cnt + (AW+1)'(1) == w_pairs) ?
                                      sqg_pkg::S_RESULT : sqg_pkg::S_AP_RD;
            sqg_pkg::S_RESULT:  n_state = sqg_pkg::S_IDLE;
            default:            n_state = sqg_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wre   = '0;
        w_wim   = '0;
        w_ra    = AW'(r_cmd.amp_index);
        w_rb    = r_ja;
        unique case (r_state)
            sqg_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                w_wre = (r_cnt == '0) ? ONE : '0;
            end
            sqg_pkg::S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_cmd.amp_index);
                w_wre   = sat_in(r_cmd.amp_real);
                w_wim   = sat_in(r_cmd.amp_imag);
            end
            sqg_pkg::S_AP_RD: begin
                w_ra = w_pi;
                w_rb = w_pi | w_mask;
            end
            sqg_pkg::S_AP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_wsel ? r_ja : r_ia;
                w_wre   = r_wsel ? r_nre_j : rescale(r_s[0]);
                w_wim   = r_wsel ? r_nim_j : rescale(r_s[1]);
            end
            default: ;
        endcase
    end

    assign o_cmd_pop = (r_state == sqg_pkg::S_RESULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sqg_pkg::S_IDLE;
            r_cnt      <= '0;
            r_wsel     <= 1'b0;
            r_out_v    <= 1'b0;
            r_clr_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sqg_pkg::S_IDLE) begin
                r_cnt  <= '0;
                r_wsel <= 1'b0;
            end else if (r_state == sqg_pkg::S_CLEAR) begin
                r_cnt <= r_cnt + (AW+1)'(1);
                if (n_state != sqg_pkg::S_CLEAR) r_clr_done <= 1'b1;
            end else if (r_state == sqg_pkg::S_AP_WR) begin
                r_wsel <= ~r_wsel;
                if (r_wsel) r_cnt <= r_cnt + (AW+1)'(1);
            end
            if (o_cmd_pop) r_out_v <= 1'b1;
            else if (r_out_v && !i_stall) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sqg_pkg::S_IDLE) r_cmd <= i_cmd;
        // hold the pair addresses for both writes
        if (r_state == sqg_pkg::S_AP_RD) begin
            r_ia <= w_pi;
            r_ja <= w_pi | w_mask;
        end
        if (o_cmd_pop) begin
            r_out.status   <= r_cmd.status;
            r_out.out_real <= '0;
            r_out.out_imag <= '0;
            if (r_cmd.status == sqg_pkg::ST_OK &&
                sqg_pkg::t_op'(r_cmd.op) == sqg_pkg::OP_READ) begin
                r_out.out_real <= sat16(w_dre_a);
                r_out.out_imag <= sat16(w_dim_a);
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;
endmodule

>>> src/sqg_checker.sv
// ----------------------------------------------------------------------------
// sqg_checker: port-level checks for the gate engine
// Watches output handshake and result codes.
// ----------------------------------------------------------------------------
module sqg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input sqg_pkg::t_out_item o_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.status == sqg_pkg::ST_OK ||
                    o_item.status == sqg_pkg::ST_BAD_TGT ||
                    o_item.status == sqg_pkg::ST_BAD_IDX)
        else $error("undefined status");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != sqg_pkg::ST_OK |->
            o_item.out_real == '0 && o_item.out_imag == '0)
        else $error("error result carries data");
endmodule

bind single_qubit_gate_apply sqg_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_item);
